// ===== rtl/pmpt_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet tracker.
`default_nettype none

package pmpt_pkg;

   // Width of the motion accumulators (valid range 9 to 32).
   localparam int ACC_WIDTH = 16;
   localparam int OUT_WIDTH = 16;

   localparam logic [7:0] BYTE_ACK      = 8'hFA;
   localparam logic [7:0] CMD_ENABLE    = 8'hF4;
   localparam logic [7:0] CMD_RESET     = 8'hFF;
   localparam logic [7:0] BYTE_SELFTEST = 8'hAA;
   localparam logic [7:0] BYTE_MOUSE_ID = 8'h00;
   localparam logic [7:0] CMD_NONE      = 8'h00;
   localparam logic [2:0] BUTTON_MASK   = 3'h7;
   localparam int         SYNC_BIT      = 3;

   typedef enum logic [1:0] {
      ACT_SEND = 2'd0,
      ACT_RECV = 2'd1,
      ACT_READ = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      EV_CMD  = 3'd0,
      EV_ACK  = 3'd1,
      EV_PKT  = 3'd2,
      EV_DROP = 3'd3,
      EV_SELF = 3'd4,
      EV_ID   = 3'd5,
      EV_UNK  = 3'd6,
      EV_READ = 3'd7
   } evt_type;

   typedef enum logic [1:0] {
      POS_HEAD = 2'd0,
      POS_X    = 2'd1,
      POS_Y    = 2'd2,
      POS_BAD  = 2'd3
   } pos_type;

   typedef struct packed {
      logic [7:0]                  pending;
      logic                        reporting;
      pos_type                     position;
      logic [2:0]                  buttons;
      logic signed [ACC_WIDTH-1:0] x_total;
      logic signed [ACC_WIDTH-1:0] y_total;
   } state_type;

   typedef struct packed {
      evt_type                     evt;
      logic [7:0]                  tx_byte;
      logic [2:0]                  buttons;
      logic signed [OUT_WIDTH-1:0] x_motion;
      logic signed [OUT_WIDTH-1:0] y_motion;
      logic                        reporting;
      logic                        done;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/pmpt_decode.sv =====
// Per-request decode: next tracker state and result from the current state.
`default_nettype none

module pmpt_decode (
   input  var pmpt_pkg::state_type  state_cur,
   input  var pmpt_pkg::action_type action,
   input  var logic [7:0]           data_byte,
   output pmpt_pkg::state_type      state_nxt,
   output pmpt_pkg::result_type     result
);

   localparam int SUM_W = pmpt_pkg::ACC_WIDTH + 1;
   localparam int EXT_W = (pmpt_pkg::ACC_WIDTH > pmpt_pkg::OUT_WIDTH) ?
                          pmpt_pkg::ACC_WIDTH : pmpt_pkg::OUT_WIDTH;

   // Add a signed byte step, clamp at the accumulator limits.
   function automatic logic signed [pmpt_pkg::ACC_WIDTH-1:0] sat_add(
      input logic signed [pmpt_pkg::ACC_WIDTH-1:0] acc,
      input logic signed [7:0]                     step
   );
      logic signed [SUM_W-1:0] sum;
      logic signed [pmpt_pkg::ACC_WIDTH-1:0] res;
      sum = SUM_W'(acc) + SUM_W'(step);
      if (sum[SUM_W-1] != sum[SUM_W-2]) begin
         res = {sum[SUM_W-1], {(pmpt_pkg::ACC_WIDTH-1){~sum[SUM_W-1]}}};
      end else begin
         res = sum[pmpt_pkg::ACC_WIDTH-1:0];
      end
      return res;
   endfunction

   // Clamp an accumulator to the output range.
   function automatic logic signed [pmpt_pkg::OUT_WIDTH-1:0] sat_out(
      input logic signed [pmpt_pkg::ACC_WIDTH-1:0] v
   );
      logic signed [EXT_W-1:0] ext;
      logic signed [EXT_W-1:0] hi;
      logic signed [EXT_W-1:0] lo;
      ext = EXT_W'(v);
      hi  = EXT_W'({1'b0, {(pmpt_pkg::OUT_WIDTH-1){1'b1}}});
      lo  = -hi - EXT_W'(1);
      if (ext > hi) begin
         ext = hi;
      end else if (ext < lo) begin
         ext = lo;
      end
      return ext[pmpt_pkg::OUT_WIDTH-1:0];
   endfunction

   pmpt_pkg::state_type st;
   pmpt_pkg::evt_type   evt;
   logic [7:0]          tx;
   logic                done;

   always_comb begin
      st   = state_cur;
      evt  = pmpt_pkg::EV_UNK;
      tx   = '0;
      done = 1'b0;
      case (action)
         pmpt_pkg::ACT_SEND: begin
            st.pending = data_byte;
            tx         = data_byte;
            evt        = pmpt_pkg::EV_CMD;
         end
         pmpt_pkg::ACT_READ: begin
            evt = pmpt_pkg::EV_READ;
         end
         pmpt_pkg::ACT_RECV: begin
            if (state_cur.pending != pmpt_pkg::CMD_NONE &&
                data_byte inside {pmpt_pkg::BYTE_ACK, pmpt_pkg::CMD_ENABLE}) begin
               evt = pmpt_pkg::EV_ACK;
               if (state_cur.pending == pmpt_pkg::CMD_ENABLE) begin
                  st.position  = pmpt_pkg::POS_HEAD;
                  st.reporting = 1'b1;
               end
               if (state_cur.pending == pmpt_pkg::CMD_RESET) begin
                  st.reporting = 1'b0;
               end
               st.pending = pmpt_pkg::CMD_NONE;
            end else if (state_cur.reporting) begin
               evt = pmpt_pkg::EV_PKT;
               case (state_cur.position)
                  pmpt_pkg::POS_X: begin
                     st.x_total  = sat_add(state_cur.x_total, data_byte);
                     st.position = pmpt_pkg::POS_Y;
                  end
                  pmpt_pkg::POS_Y: begin
                     st.y_total  = sat_add(state_cur.y_total, data_byte);
                     st.position = pmpt_pkg::POS_HEAD;
                     done        = 1'b1;
                  end
                  default: begin
                     // Head byte, or a stray position treated as head.
                     if (!data_byte[pmpt_pkg::SYNC_BIT]) begin
                        evt         = pmpt_pkg::EV_DROP;
                        st.position = pmpt_pkg::POS_HEAD;
                     end else begin
                        st.buttons  = data_byte[2:0] & pmpt_pkg::BUTTON_MASK;
                        st.position = pmpt_pkg::POS_X;
                     end
                  end
               endcase
            end else if (data_byte == pmpt_pkg::BYTE_SELFTEST) begin
               evt = pmpt_pkg::EV_SELF;
            end else if (data_byte == pmpt_pkg::BYTE_MOUSE_ID) begin
               evt = pmpt_pkg::EV_ID;
            end else begin
               evt = pmpt_pkg::EV_UNK;
            end
         end
         default: begin
            // No-op request: state untouched, no response.
         end
      endcase

      result.evt       = evt;
      result.tx_byte   = tx;
      result.buttons   = st.buttons;
      result.x_motion  = sat_out(st.x_total);
      result.y_motion  = sat_out(st.y_total);
      result.reporting = st.reporting;
      result.done      = done;

      // Report motion before clearing it.
      if (evt == pmpt_pkg::EV_READ) begin
         st.x_total = '0;
         st.y_total = '0;
      end
      state_nxt = st;
   end

endmodule

`default_nettype wire

// ===== rtl/ps2_mouse_packet_tracker_core.sv =====
// Top level of the PS/2 mouse packet tracker: request register, decode, response register.
//
// Usage:
//   Request channel (req_valid/req_ready): req_action selects send command (0),
//   received mouse byte (1) or read-and-clear motion (2); req_data_byte carries
//   the command or received byte. Action 3 is taken and dropped with no response.
//   Response channel (rsp_valid/rsp_ready): one response per other request, with
//   the event code, transmit byte, buttons, saturated X/Y motion, reporting flag
//   and packet-complete flag.
//   Path: an accepted request goes to the request register, then is decoded into
//   the response register.
//   Throughput: one request per cycle while responses are taken; all tracker state
//   updates in the single decode step, so back-to-back requests see each other's effects.
//   Stall: when the response is not taken, the request register holds one more
//   request and then req_ready drops; nothing is lost or repeated.
//   Reset: synchronous; clears both stage valids, the pending command,
//   reporting flag, packet position, buttons and motion accumulators.
`default_nettype none

module ps2_mouse_packet_tracker_core (
   input  var logic              clock,
   input  var logic              reset,
   input  var logic              req_valid,
   output logic                  req_ready,
   input  var logic [1:0]        req_action,
   input  var logic [7:0]        req_data_byte,
   output logic                  rsp_valid,
   input  var logic              rsp_ready,
   output logic [2:0]            rsp_event_res,
   output logic [7:0]            rsp_tx_byte,
   output logic [2:0]            rsp_button_bits,
   output logic signed [15:0]    rsp_x_motion,
   output logic signed [15:0]    rsp_y_motion,
   output logic                  rsp_reporting_active,
   output logic                  rsp_packet_done
);

   logic                 in_valid_ff;
   pmpt_pkg::action_type in_action_ff;
   logic [7:0]           in_byte_ff;
   pmpt_pkg::state_type  state_ff;
   pmpt_pkg::state_type  state_in;
   pmpt_pkg::result_type result_in;
   pmpt_pkg::result_type result_ff;
   logic                 rsp_valid_ff;
   logic                 no_rsp;
   logic                 advance;

   assign no_rsp    = (in_action_ff == pmpt_pkg::ACT_NONE);
   assign advance   = in_valid_ff && (no_rsp || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   pmpt_decode u_decode (
      .state_cur (state_ff),
      .action    (in_action_ff),
      .data_byte (in_byte_ff),
      .state_nxt (state_in),
      .result    (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance && !no_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_action_ff <= pmpt_pkg::action_type'(req_action);
         in_byte_ff   <= req_data_byte;
      end
      if (advance && !no_rsp) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_event_res        = result_ff.evt;
   assign rsp_tx_byte          = result_ff.tx_byte;
   assign rsp_button_bits      = result_ff.buttons;
   assign rsp_x_motion         = result_ff.x_motion;
   assign rsp_y_motion         = result_ff.y_motion;
   assign rsp_reporting_active = result_ff.reporting;
   assign rsp_packet_done      = result_ff.done;

   a_pos_legal: assert property (@(posedge clock) disable iff (reset)
      state_ff.position != pmpt_pkg::POS_BAD)
      else $error("packet position reached an illegal value");

   a_done_is_pkt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_done |-> rsp_event_res == pmpt_pkg::EV_PKT)
      else $error("packet done without packet event");

   a_tx_only_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != pmpt_pkg::EV_CMD |-> rsp_tx_byte == 8'h00)
      else $error("transmit byte set on a non-command response");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_ff))
      else $error("stalled response was overwritten");

   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_action_ff == pmpt_pkg::ACT_READ |=>
         state_ff.x_total == '0 && state_ff.y_total == '0)
      else $error("read did not clear motion");

endmodule

`default_nettype wire
